### design/perlin_gradient_noise_3d_assert.svh
// Assertion macros shared by the noise core.
`ifndef PERLIN_GRADIENT_NOISE_3D_ASSERT_SVH
`define PERLIN_GRADIENT_NOISE_3D_ASSERT_SVH

`ifndef SYNTHESIS
// same-cycle implication
`define PGN_ASSERT_IMP(name, clk, rstn, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error("assertion failed: implication");
// next-cycle implication
`define PGN_ASSERT_NXT(name, clk, rstn, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error("assertion failed: next cycle");
`else
`define PGN_ASSERT_IMP(name, clk, rstn, ante, cons)
`define PGN_ASSERT_NXT(name, clk, rstn, ante, cons)
`endif

`endif

### design/pgn3d_pkg.sv
`timescale 1ns / 1ps
package pgn3d_pkg;

    // request kinds carried in s_axis_tuser
    typedef enum logic [1:0] {
        REQ_SAMPLE    = 2'd0,
        REQ_TURB      = 2'd1,
        REQ_LOAD_PERM = 2'd2,
        REQ_LOAD_GRAD = 2'd3
    } req_t;

    // permutation table select
    localparam logic [1:0] AXIS_X = 2'd0;
    localparam logic [1:0] AXIS_Y = 2'd1;
    localparam logic [1:0] AXIS_Z = 2'd2;

    localparam int COORD_W = 24;
    localparam int GRAD_W  = 16;
    localparam int PERM_W  = 8;
    localparam int OUT_W   = 19;

    // sequencer states
    typedef enum logic [3:0] {
        ST_IDLE,
        ST_H1,
        ST_H2,
        ST_CORNER,
        ST_HASH,
        ST_W,
        ST_D0,
        ST_D1,
        ST_D2,
        ST_PL,
        ST_PH,
        ST_OCT_END,
        ST_FIN
    } state_t;

endpackage

### design/perlin_gradient_noise_3d.sv
`timescale 1ns / 1ps
// 3D Perlin gradient noise and turbulence on one shared signed multiplier. Every product
// goes through that multiplier under a small sequencer, so the block takes one word at a
// time and deasserts s_axis_tready while it works. A table load goes straight to the
// result state. A sample computes the Hermite weights of the three axes, then visits each
// of the 8 lattice corners in turn, then closes the octave. A turbulence word repeats
// that per octave (up to MAX_OCTAVES). The next word is taken while a finished result
// still waits in the output register. Tables are not cleared: an entry must be loaded
// before a sample reads it.
module perlin_gradient_noise_3d
    import pgn3d_pkg::*;
#(
    parameter int TABLE_SIZE  = 256,
    parameter int FRAC_BITS   = 16,
    parameter int MAX_OCTAVES = 8
) (
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         s_axis_tvalid,
    output logic         s_axis_tready,
    // coord_x, coord_y, coord_z, octaves, table_axis, entry_index, perm_value,
    // grad_x, grad_y, grad_z, zero pad
    input  logic [143:0] s_axis_tdata,
    // req_type
    input  logic [1:0]   s_axis_tuser,
    output logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    // noise_value, zero pad
    output logic [23:0]  m_axis_tdata,
    // load_ack
    output logic         m_axis_tuser
);

    localparam int F    = FRAC_BITS;
    localparam int IW   = $clog2(TABLE_SIZE);
    localparam int CW   = F + IW;
    localparam int MW   = (F + 3 > 17) ? F + 3 : 17;
    localparam int DW   = F + 18;
    localparam int AW   = 2 * F + 21;
    localparam int SMPW = F + 7;
    localparam int TRAW = F + 8 + MAX_OCTAVES;
    localparam int TW   = (TRAW > 20) ? TRAW : 20;
    localparam int OW   = $clog2(MAX_OCTAVES + 1);
    localparam int ONE_I = 1 << FRAC_BITS;
    localparam logic [F:0]   ONE_W     = (F + 1)'(ONE_I);
    localparam logic [F+1:0] THREE_ONE = (F + 2)'(3 * ONE_I);
    localparam logic signed [TW-1:0] OUT_MAX_T = TW'(262143);
    localparam logic signed [TW-1:0] OUT_MIN_T = TW'(-262144);

    // input word fields
    logic [COORD_W-1:0] in_cx, in_cy, in_cz;
    logic [3:0]         in_oct;
    logic [1:0]         in_axis;
    logic [7:0]         in_idx;
    logic [PERM_W-1:0]  in_pv;
    logic [GRAD_W-1:0]  in_gx, in_gy, in_gz;
    req_t               in_req;
    logic               accept;

    assign in_cx   = s_axis_tdata[23:0];
    assign in_cy   = s_axis_tdata[47:24];
    assign in_cz   = s_axis_tdata[71:48];
    assign in_oct  = s_axis_tdata[75:72];
    assign in_axis = s_axis_tdata[77:76];
    assign in_idx  = s_axis_tdata[85:78];
    assign in_pv   = s_axis_tdata[93:86];
    assign in_gx   = s_axis_tdata[109:94];
    assign in_gy   = s_axis_tdata[125:110];
    assign in_gz   = s_axis_tdata[141:126];
    assign in_req  = req_t'(s_axis_tuser);

    state_t state_reg, state_next;
    logic   m_valid_reg;
    logic [OUT_W-1:0] m_noise_reg;
    logic   m_ack_reg;

    assign s_axis_tready = (state_reg == ST_IDLE);
    assign accept        = s_axis_tvalid && s_axis_tready;
    assign m_axis_tvalid = m_valid_reg;
    assign m_axis_tdata  = {{(24 - OUT_W){1'b0}}, m_noise_reg};
    assign m_axis_tuser  = m_ack_reg;

    // working registers
    req_t              req_reg;
    logic [CW-1:0]     cx_reg, cy_reg, cz_reg;
    logic [OW-1:0]     oct_reg, k_reg;
    logic [1:0]        ax_reg;
    logic [2:0]        cn_reg;
    logic [F-1:0]      f2_reg;
    logic [F:0]        sx_reg, sy_reg, sz_reg;
    logic [F:0]        wxy_reg, w_reg;
    logic signed [DW-1:0]   dot_reg;
    logic signed [AW-1:0]   acc_reg;
    logic signed [SMPW-1:0] smp_reg;
    logic signed [TW-1:0]   tacc_reg;
    logic [PERM_W-1:0] px_rd_reg, py_rd_reg, pz_rd_reg;
    logic [3*GRAD_W-1:0] g_rd_reg;

    // table memories
    logic [PERM_W-1:0]   perm_x_mem [TABLE_SIZE];
    logic [PERM_W-1:0]   perm_y_mem [TABLE_SIZE];
    logic [PERM_W-1:0]   perm_z_mem [TABLE_SIZE];
    logic [3*GRAD_W-1:0] grad_mem   [TABLE_SIZE];

    logic [IW-1:0] widx;
    logic [OW-1:0] oct_clamp;
    assign widx      = IW'(in_idx);
    assign oct_clamp = (int'(in_oct) > MAX_OCTAVES) ? OW'(MAX_OCTAVES) : OW'(in_oct);

    // lattice cell and fractions of the current octave
    logic [IW-1:0] ix, iy, iz;
    logic [F-1:0]  fx, fy, fz, f_cur;
    assign ix = cx_reg[CW-1:F];
    assign iy = cy_reg[CW-1:F];
    assign iz = cz_reg[CW-1:F];
    assign fx = cx_reg[F-1:0];
    assign fy = cy_reg[F-1:0];
    assign fz = cz_reg[F-1:0];
    assign f_cur = (ax_reg == AXIS_X) ? fx : ((ax_reg == AXIS_Y) ? fy : fz);

    // corner bits: a for x, b for y, c for z
    logic ca, cb, cc;
    assign ca = cn_reg[2];
    assign cb = cn_reg[1];
    assign cc = cn_reg[0];

    logic [IW-1:0] xaddr, yaddr, zaddr, haddr;
    assign xaddr = ix + IW'(ca);
    assign yaddr = iy + IW'(cb);
    assign zaddr = iz + IW'(cc);
    assign haddr = IW'(px_rd_reg ^ py_rd_reg ^ pz_rd_reg);

    logic [F:0] wx, wy, wz;
    assign wx = ca ? sx_reg : ONE_W - sx_reg;
    assign wy = cb ? sy_reg : ONE_W - sy_reg;
    assign wz = cc ? sz_reg : ONE_W - sz_reg;

    logic signed [F:0] ox, oy, oz;
    assign ox = ca ? $signed({1'b0, fx} - ONE_W) : $signed({1'b0, fx});
    assign oy = cb ? $signed({1'b0, fy} - ONE_W) : $signed({1'b0, fy});
    assign oz = cc ? $signed({1'b0, fz} - ONE_W) : $signed({1'b0, fz});

    logic signed [GRAD_W-1:0] gx, gy, gz;
    assign gx = $signed(g_rd_reg[GRAD_W-1:0]);
    assign gy = $signed(g_rd_reg[2*GRAD_W-1:GRAD_W]);
    assign gz = $signed(g_rd_reg[3*GRAD_W-1:2*GRAD_W]);

    logic [F+1:0] three_m2f;
    assign three_m2f = THREE_ONE - (F + 2)'({f_cur, 1'b0});

    // shared multiplier operand select
    logic signed [MW-1:0]   mul_a, mul_b;
    logic signed [2*MW-1:0] prod;
    always_comb begin
        mul_a = '0;
        mul_b = '0;
        unique case (state_reg)
            ST_H1: begin
                mul_a = $signed(MW'(f_cur));
                mul_b = $signed(MW'(f_cur));
            end
            ST_H2: begin
                mul_a = $signed(MW'(f2_reg));
                mul_b = $signed(MW'(three_m2f));
            end
            ST_HASH: begin
                mul_a = $signed(MW'(wx));
                mul_b = $signed(MW'(wy));
            end
            ST_W: begin
                mul_a = $signed(MW'(wxy_reg));
                mul_b = $signed(MW'(wz));
            end
            ST_D0: begin
                mul_a = MW'(gx);
                mul_b = MW'(ox);
            end
            ST_D1: begin
                mul_a = MW'(gy);
                mul_b = MW'(oy);
            end
            ST_D2: begin
                mul_a = MW'(gz);
                mul_b = MW'(oz);
            end
            ST_PL: begin
                mul_a = $signed(MW'(dot_reg[F:0]));
                mul_b = $signed(MW'(w_reg));
            end
            ST_PH: begin
                mul_a = MW'($signed(dot_reg[DW-1:F+1]));
                mul_b = $signed(MW'(w_reg));
            end
            default: begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end
    assign prod = mul_a * mul_b;

    // octave close: floor shift of the corner sum, weighted turbulence add
    logic signed [AW-1:0]   acc_shr;
    logic signed [SMPW-1:0] smp_now;
    logic [OW-1:0]          oct_shamt;
    assign acc_shr   = acc_reg >>> (14 + F);
    assign smp_now   = acc_shr[SMPW-1:0];
    assign oct_shamt = OW'(MAX_OCTAVES) - k_reg;

    function automatic logic [OUT_W-1:0] sat_out(input logic signed [TW-1:0] v);
        logic signed [TW-1:0] t;
        t = v;
        if (v > OUT_MAX_T) t = OUT_MAX_T;
        if (v < OUT_MIN_T) t = OUT_MIN_T;
        return t[OUT_W-1:0];
    endfunction

    logic signed [TW-1:0] turb_abs;
    logic signed [TW-1:0] turb_res;
    logic [OUT_W-1:0]     res_noise;
    assign turb_abs = (tacc_reg < 0) ? -tacc_reg : tacc_reg;
    assign turb_res = turb_abs >>> MAX_OCTAVES;
    always_comb begin
        priority if (req_reg == REQ_LOAD_PERM || req_reg == REQ_LOAD_GRAD) begin
            res_noise = '0;
        end else if (req_reg == REQ_SAMPLE) begin
            res_noise = sat_out(TW'(smp_reg));
        end else begin
            res_noise = sat_out(turb_res);
        end
    end

    logic out_free;
    assign out_free = !m_valid_reg || m_axis_tready;

    // state register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    // next state
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE: begin
                if (accept) begin
                    priority if (in_req == REQ_LOAD_PERM || in_req == REQ_LOAD_GRAD) begin
                        state_next = ST_FIN;
                    end else if (in_req == REQ_TURB && oct_clamp == '0) begin
                        state_next = ST_FIN;
                    end else begin
                        state_next = ST_H1;
                    end
                end
            end
            ST_H1:     state_next = ST_H2;
            ST_H2:     state_next = (ax_reg == AXIS_Z) ? ST_CORNER : ST_H1;
            ST_CORNER: state_next = ST_HASH;
            ST_HASH:   state_next = ST_W;
            ST_W:      state_next = ST_D0;
            ST_D0:     state_next = ST_D1;
            ST_D1:     state_next = ST_D2;
            ST_D2:     state_next = ST_PL;
            ST_PL:     state_next = ST_PH;
            ST_PH:     state_next = (cn_reg == 3'd7) ? ST_OCT_END : ST_CORNER;
            ST_OCT_END: begin
                if (req_reg == REQ_SAMPLE || k_reg + OW'(1) == oct_reg) begin
                    state_next = ST_FIN;
                end else begin
                    state_next = ST_H1;
                end
            end
            ST_FIN:    state_next = out_free ? ST_IDLE : ST_FIN;
            default:   state_next = ST_IDLE;
        endcase
    end

    // datapath
    always_ff @(posedge aclk) begin
        unique case (state_reg)
            ST_IDLE: begin
                if (accept) begin
                    req_reg  <= in_req;
                    cx_reg   <= CW'(in_cx);
                    cy_reg   <= CW'(in_cy);
                    cz_reg   <= CW'(in_cz);
                    oct_reg  <= oct_clamp;
                    k_reg    <= '0;
                    ax_reg   <= AXIS_X;
                    cn_reg   <= '0;
                    acc_reg  <= '0;
                    tacc_reg <= '0;
                end
            end
            ST_H1: f2_reg <= prod[2*F-1:F];
            ST_H2: begin
                unique case (ax_reg)
                    AXIS_X:  sx_reg <= prod[2*F:F];
                    AXIS_Y:  sy_reg <= prod[2*F:F];
                    default: sz_reg <= prod[2*F:F];
                endcase
                ax_reg <= ax_reg + 2'd1;
            end
            ST_HASH: wxy_reg <= prod[2*F:F];
            ST_W:    w_reg   <= prod[2*F:F];
            ST_D0:   dot_reg <= $signed(prod[DW-1:0]);
            ST_D1:   dot_reg <= dot_reg + $signed(prod[DW-1:0]);
            ST_D2:   dot_reg <= dot_reg + $signed(prod[DW-1:0]);
            ST_PL:   acc_reg <= acc_reg + AW'(prod);
            ST_PH: begin
                acc_reg <= acc_reg + (AW'(prod) <<< (F + 1));
                cn_reg  <= cn_reg + 3'd1;
            end
            ST_OCT_END: begin
                smp_reg  <= smp_now;
                tacc_reg <= tacc_reg + (TW'(smp_now) <<< oct_shamt);
                k_reg    <= k_reg + OW'(1);
                cx_reg   <= {cx_reg[CW-2:0], 1'b0};
                cy_reg   <= {cy_reg[CW-2:0], 1'b0};
                cz_reg   <= {cz_reg[CW-2:0], 1'b0};
                ax_reg   <= AXIS_X;
                acc_reg  <= '0;
            end
            default: begin
            end
        endcase
    end

    // permutation tables: load write, corner read
    always_ff @(posedge aclk) begin
        if (accept && in_req == REQ_LOAD_PERM && in_axis == AXIS_X) perm_x_mem[widx] <= in_pv;
        if (state_reg == ST_CORNER) px_rd_reg <= perm_x_mem[xaddr];
    end
    always_ff @(posedge aclk) begin
        if (accept && in_req == REQ_LOAD_PERM && in_axis == AXIS_Y) perm_y_mem[widx] <= in_pv;
        if (state_reg == ST_CORNER) py_rd_reg <= perm_y_mem[yaddr];
    end
    always_ff @(posedge aclk) begin
        if (accept && in_req == REQ_LOAD_PERM && in_axis == AXIS_Z) perm_z_mem[widx] <= in_pv;
        if (state_reg == ST_CORNER) pz_rd_reg <= perm_z_mem[zaddr];
    end

    // gradient table: read at the corner hash
    always_ff @(posedge aclk) begin
        if (accept && in_req == REQ_LOAD_GRAD) grad_mem[widx] <= {in_gz, in_gy, in_gx};
        if (state_reg == ST_HASH) g_rd_reg <= grad_mem[haddr];
    end

    // output word register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (state_reg == ST_FIN && out_free) begin
            m_valid_reg <= 1'b1;
        end else if (m_axis_tready) begin
            m_valid_reg <= 1'b0;
        end
    end
    always_ff @(posedge aclk) begin
        if (state_reg == ST_FIN && out_free) begin
            m_noise_reg <= res_noise;
            m_ack_reg   <= (req_reg == REQ_LOAD_PERM || req_reg == REQ_LOAD_GRAD);
        end
    end

`include "perlin_gradient_noise_3d_assert.svh"

    // a load goes straight to the result stage
    `PGN_ASSERT_NXT(a_load_to_fin, aclk, aresetn, accept && (in_req == REQ_LOAD_PERM || in_req == REQ_LOAD_GRAD), state_reg == ST_FIN)
    // load acknowledgments carry a zero value
    `PGN_ASSERT_IMP(a_ack_zero, aclk, aresetn, m_valid_reg && m_ack_reg, m_noise_reg == '0)
    // the eighth corner closes the octave
    `PGN_ASSERT_NXT(a_last_corner, aclk, aresetn, state_reg == ST_PH && cn_reg == 3'd7, state_reg == ST_OCT_END)
    // the octave counter never passes the requested count while busy
    `PGN_ASSERT_IMP(a_oct_bound, aclk, aresetn, state_reg == ST_H1 && req_reg == REQ_TURB, k_reg < oct_reg)

endmodule
